// ===== rtl/iff_pkg.sv =====
`default_nettype none

package iff_pkg;

  // default cap on emitted characters per request
  localparam int MAX_FIELD_DEF = 64;

  // digit buffer depth (decimal needs at most 10, hex 8)
  localparam int DIG_DEPTH = 16;

  // conversion codes
  localparam logic [2:0] CMD_CHAR = 3'd0;
  localparam logic [2:0] CMD_SDEC = 3'd1;
  localparam logic [2:0] CMD_UDEC = 3'd2;
  localparam logic [2:0] CMD_LHEX = 3'd3;
  localparam logic [2:0] CMD_UHEX = 3'd4;

  // sign modes for non-negative signed decimal
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_SPACE = 2'd2;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;

  // floor(x / 10) == (x * RECIP_TEN) >> 35 for every 32-bit x
  localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIG,
    ST_SIZE,
    ST_EMIT,
    ST_NONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic dig;
    logic size;
    logic emit;
    logic empty;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_digits;
    logic q_zero;
    logic total_zero;
    logic emit_last;
  } ctrl_stat_t;

  // one hex or decimal digit as a character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    if (d < 4'd10) begin
      return CH_ZERO + {4'h0, d};
    end
    return (upper ? CH_UA : CH_LA) + {4'h0, d} - 8'd10;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/iff_ctrl.sv =====
`default_nettype none

module iff_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  iff_pkg::ctrl_stat_t stat,
  output logic               busy,
  output iff_pkg::ctrl_cmd_t  ctl
);
  import iff_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = stat.need_digits ? ST_MUL : ST_SIZE;
      end
      ST_MUL: begin
        ctl.mul    = 1'b1;
        state_next = ST_DIG;
      end
      ST_DIG: begin
        ctl.dig    = 1'b1;
        state_next = stat.q_zero ? ST_SIZE : ST_MUL;
      end
      ST_SIZE: begin
        ctl.size   = 1'b1;
        state_next = stat.total_zero ? ST_NONE : ST_EMIT;
      end
      ST_EMIT: begin
        ctl.emit = 1'b1;
        if (stat.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_NONE: begin
        ctl.empty  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/iff_datapath.sv =====
`default_nettype none

module iff_datapath #(
  parameter int MAX_FIELD = iff_pkg::MAX_FIELD_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  iff_pkg::ctrl_cmd_t  ctl,
  output iff_pkg::ctrl_stat_t stat,
  input  logic [2:0]          cmd,
  input  logic [31:0]         value,
  input  logic [6:0]          field_width,
  input  logic [5:0]          precision_digits,
  input  logic                has_precision,
  input  logic                left_justify,
  input  logic                zero_pad,
  input  logic [1:0]          sign_mode,
  input  logic                alt_prefix,
  output logic                strobe,
  output logic [7:0]          out_char,
  output logic                char_valid,
  output logic                last,
  output logic [6:0]          total_length
);
  import iff_pkg::*;

  localparam logic [7:0] MAX_LEN = 8'(MAX_FIELD);

  // request registers
  logic [2:0]  cmd_r;
  logic [7:0]  byte_r;
  logic        val_zero_r;
  logic [6:0]  fw_r;
  logic [5:0]  prec_r;
  logic        hasp_r;
  logic        left_r;
  logic        zpad_r;
  logic        upper_r;
  logic        hex_r;
  logic [1:0]  plen_r;
  logic [7:0]  pre_ch_r;

  // digit extraction
  logic [31:0] mag;
  logic [31:0] quo;
  logic [3:0]  digs [DIG_DEPTH];
  logic [4:0]  ndig;
  logic [63:0] prod;
  logic [31:0] rem;
  logic [3:0]  digit;

  // emission counters
  logic [6:0]  lb_cnt;
  logic [6:0]  tb_cnt;
  logic [6:0]  z_cnt;
  logic [1:0]  p_cnt;
  logic [4:0]  d_cnt;
  logic [6:0]  emit_cnt;
  logic [6:0]  total_r;

  // sign or prefix of the incoming request
  logic [1:0]  pre_len_in;
  logic [7:0]  pre_ch_in;

  always_comb begin
    pre_len_in = 2'd0;
    pre_ch_in  = CH_SPACE;
    case (cmd) inside
      CMD_SDEC: begin
        if (value[31]) begin
          pre_len_in = 2'd1;
          pre_ch_in  = CH_MINUS;
        end else if (sign_mode == SIGN_PLUS) begin
          pre_len_in = 2'd1;
          pre_ch_in  = CH_PLUS;
        end else if (sign_mode == SIGN_SPACE) begin
          pre_len_in = 2'd1;
          pre_ch_in  = CH_SPACE;
        end
      end
      CMD_LHEX, CMD_UHEX: begin
        if (alt_prefix) begin
          pre_len_in = 2'd2;
          pre_ch_in  = (cmd == CMD_UHEX) ? CH_UX : CH_LX;
        end
      end
      default: begin
        pre_len_in = 2'd0;
      end
    endcase
  end

  logic is_num;
  logic is_char;

  assign is_num  = (cmd_r == CMD_SDEC) || (cmd_r == CMD_UDEC) ||
                   (cmd_r == CMD_LHEX) || (cmd_r == CMD_UHEX);
  assign is_char = (cmd_r == CMD_CHAR);

  // divide by ten through the reciprocal; remainder from q*10 by shifts
  assign prod  = {32'd0, mag} * {32'd0, RECIP_TEN};
  assign rem   = mag - {quo[28:0], 3'b000} - {quo[30:0], 1'b0};
  assign digit = hex_r ? mag[3:0] : rem[3:0];

  // field layout
  logic [7:0] ndig8, prec8, fw8, plen8;
  logic [7:0] zprec, core, zfill, body, body_sel, blanks, total_raw, total_clip;

  always_comb begin
    ndig8 = {3'b000, ndig};
    prec8 = {2'b00, prec_r};
    fw8   = {1'b0, fw_r};
    plen8 = {6'd0, plen_r};
    zprec = (hasp_r && prec8 > ndig8) ? prec8 - ndig8 : 8'd0;
    core  = ndig8 + zprec;
    zfill = (zpad_r && fw8 >= plen8 && (fw8 - plen8) > core) ? fw8 - plen8 - core : 8'd0;
    body  = plen8 + zfill + core;
    if (is_char) begin
      body_sel = 8'd1;
      blanks   = (fw8 > 8'd1) ? fw8 - 8'd1 : 8'd0;
    end else if (is_num) begin
      body_sel = body;
      blanks   = (!zpad_r && fw8 > body) ? fw8 - body : 8'd0;
    end else begin
      body_sel = 8'd0;
      blanks   = 8'd0;
    end
    total_raw  = blanks + body_sel;
    total_clip = (total_raw > MAX_LEN) ? MAX_LEN : total_raw;
  end

  // character selection: lead blanks, prefix, zeros, digits, trail blanks
  logic [4:0] d_idx;
  logic [7:0] emit_ch;

  assign d_idx = d_cnt - 5'd1;

  always_comb begin
    if (lb_cnt != 7'd0) begin
      emit_ch = CH_SPACE;
    end else if (p_cnt == 2'd2) begin
      emit_ch = CH_ZERO;
    end else if (p_cnt == 2'd1) begin
      emit_ch = pre_ch_r;
    end else if (z_cnt != 7'd0) begin
      emit_ch = CH_ZERO;
    end else if (d_cnt != 5'd0) begin
      emit_ch = is_char ? byte_r : digit_char(digs[d_idx[3:0]], upper_r);
    end else begin
      emit_ch = CH_SPACE;
    end
  end

  // status to controller
  always_comb begin
    stat.need_digits = is_num && !(val_zero_r && hasp_r && prec_r == 6'd0);
    stat.q_zero      = (quo == 32'd0);
    stat.total_zero  = (total_raw == 8'd0);
    stat.emit_last   = (({1'b0, emit_cnt} + 8'd1) == {1'b0, total_r});
  end

  // request capture, digit extraction and counters
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r      <= cmd;
      byte_r     <= value[7:0];
      val_zero_r <= (value == 32'd0);
      fw_r       <= field_width;
      prec_r     <= precision_digits;
      hasp_r     <= has_precision;
      left_r     <= left_justify;
      zpad_r     <= zero_pad;
      upper_r    <= (cmd == CMD_UHEX);
      hex_r      <= (cmd == CMD_LHEX) || (cmd == CMD_UHEX);
      plen_r     <= pre_len_in;
      pre_ch_r   <= pre_ch_in;
      mag        <= (cmd == CMD_SDEC && value[31]) ? 32'd0 - value : value;
      ndig       <= 5'd0;
    end
    if (ctl.mul) begin
      quo <= hex_r ? {4'd0, mag[31:4]} : {3'd0, prod[63:35]};
    end
    if (ctl.dig) begin
      digs[ndig[3:0]] <= digit;
      ndig            <= ndig + 5'd1;
      mag             <= quo;
    end
    if (ctl.size) begin
      lb_cnt   <= left_r ? 7'd0 : blanks[6:0];
      tb_cnt   <= left_r ? blanks[6:0] : 7'd0;
      p_cnt    <= is_num ? plen_r : 2'd0;
      z_cnt    <= is_num ? 7'(zfill + zprec) : 7'd0;
      d_cnt    <= is_char ? 5'd1 : ndig;
      total_r  <= total_clip[6:0];
      emit_cnt <= 7'd0;
    end
    if (ctl.emit) begin
      emit_cnt <= emit_cnt + 7'd1;
      if (lb_cnt != 7'd0) begin
        lb_cnt <= lb_cnt - 7'd1;
      end else if (p_cnt != 2'd0) begin
        p_cnt <= p_cnt - 2'd1;
      end else if (z_cnt != 7'd0) begin
        z_cnt <= z_cnt - 7'd1;
      end else if (d_cnt != 5'd0) begin
        d_cnt <= d_cnt - 5'd1;
      end else if (tb_cnt != 7'd0) begin
        tb_cnt <= tb_cnt - 7'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.emit || ctl.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit || ctl.empty) begin
      out_char     <= ctl.empty ? 8'd0 : emit_ch;
      char_valid   <= ctl.emit;
      last         <= ctl.empty || stat.emit_last;
      total_length <= ctl.empty ? 7'd0 : total_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ({1'b0, total_length} <= MAX_LEN))
    else $error("result length above cap");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    strobe && !char_valid |-> last && total_length == 7'd0)
    else $error("empty result not marked last with zero length");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("gap inside a result burst");

  a_digit_cnt: assert property (@(posedge clk) disable iff (rst)
    ctl.size |-> ndig <= 5'd10)
    else $error("too many digits extracted");
`endif

endmodule

`default_nettype wire

// ===== rtl/integer_field_formatter.sv =====
// Flow: a taken request is registered, then each of its D digits passes a multiply
//   and a digit state (D: decimal up to 10, hex up to 8; 0 for a character
//   conversion), digits coming from one divide unit; then the field is sized.
// Throughput: one character per cycle, set by the emit counter; none taken while busy.
// Reset (rst, synchronous) returns the controller to idle and drops strobe.
// The receiver cannot stall: each result shows for exactly one strobe cycle.
`default_nettype none

module integer_field_formatter #(
  parameter int MAX_FIELD = iff_pkg::MAX_FIELD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [31:0] value,
  input  logic [6:0]  field_width,
  input  logic [5:0]  precision_digits,
  input  logic        has_precision,
  input  logic        left_justify,
  input  logic        zero_pad,
  input  logic [1:0]  sign_mode,
  input  logic        alt_prefix,
  output logic        strobe,
  output logic [7:0]  out_char,
  output logic        char_valid,
  output logic        last,
  output logic [6:0]  total_length
);
  import iff_pkg::*;

  ctrl_cmd_t  ctl;
  ctrl_stat_t stat;

  iff_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctl   (ctl)
  );

  iff_datapath #(
    .MAX_FIELD (MAX_FIELD)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .stat             (stat),
    .cmd              (cmd),
    .value            (value),
    .field_width      (field_width),
    .precision_digits (precision_digits),
    .has_precision    (has_precision),
    .left_justify     (left_justify),
    .zero_pad         (zero_pad),
    .sign_mode        (sign_mode),
    .alt_prefix       (alt_prefix),
    .strobe           (strobe),
    .out_char         (out_char),
    .char_valid       (char_valid),
    .last             (last),
    .total_length     (total_length)
  );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import iff_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int TAIL_CYCLES = 120;

  // sign modes and commands that the package leaves unnamed
  localparam logic [1:0] SIGN_NONE     = 2'd0;
  localparam logic [1:0] SIGN_UNUSED   = 2'd3;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] value;
    logic [6:0]  field_width;
    logic [5:0]  precision_digits;
    logic        has_precision;
    logic        left_justify;
    logic        zero_pad;
    logic [1:0]  sign_mode;
    logic        alt_prefix;
  } fmt_req_t;

  typedef struct {
    logic [7:0] ch;
    logic       valid;
    logic       fin;
    logic [6:0] len;
  } char_res_t;

  // Expected character stream, built per request
  class text_scoreboard;
    char_res_t expected_chars[$];
    int        mismatches = 0;

    // format one request into its character results
    function void note_request(fmt_req_t r);
      logic [7:0]  field_text[$];
      logic [7:0]  lead[$];
      logic [7:0]  digit_chars[$];
      logic [31:0] mag;
      logic [3:0]  d;
      bit          hex;
      bit          upper;
      int unsigned fw;
      int unsigned zprec;
      int unsigned core;
      int unsigned zfill;
      int unsigned body;
      int unsigned blanks;
      int unsigned total;
      char_res_t   e;

      fw = r.field_width;
      if (r.cmd == CMD_CHAR) begin
        blanks = (fw > 1) ? fw - 1 : 0;
        if (!r.left_justify) repeat (blanks) field_text.push_back(CH_SPACE);
        field_text.push_back(r.value[7:0]);
        if (r.left_justify) repeat (blanks) field_text.push_back(CH_SPACE);
      end else if (r.cmd <= CMD_UHEX) begin
        hex = (r.cmd >= CMD_LHEX);
        upper = (r.cmd == CMD_UHEX);
        mag = r.value;
        // sign or 0x prefix
        if (r.cmd == CMD_SDEC) begin
          if (r.value[31]) begin
            mag = 32'd0 - r.value;
            lead.push_back(CH_MINUS);
          end else if (r.sign_mode == SIGN_PLUS) begin
            lead.push_back(CH_PLUS);
          end else if (r.sign_mode == SIGN_SPACE) begin
            lead.push_back(CH_SPACE);
          end
        end else if (hex && r.alt_prefix) begin
          lead.push_back(CH_ZERO);
          lead.push_back(upper ? CH_UX : CH_LX);
        end
        // digits, most significant first; none for zero at precision zero
        if (!(r.value == 32'd0 && r.has_precision && r.precision_digits == 6'd0)) begin
          do begin
            d = hex ? mag[3:0] : 4'(mag % 10);
            if (d < 4'd10)
              digit_chars.push_front(CH_ZERO + {4'h0, d});
            else
              digit_chars.push_front((upper ? CH_UA : CH_LA) + {4'h0, d} - 8'd10);
            mag = hex ? (mag >> 4) : (mag / 10);
          end while (mag != 32'd0);
        end
        zprec = (r.has_precision && r.precision_digits > digit_chars.size()) ?
                r.precision_digits - digit_chars.size() : 0;
        core = digit_chars.size() + zprec;
        zfill = 0;
        if (r.zero_pad && fw >= lead.size() && fw - lead.size() > core)
          zfill = fw - lead.size() - core;
        body = lead.size() + zfill + core;
        blanks = (!r.zero_pad && fw > body) ? fw - body : 0;

        if (!r.left_justify) repeat (blanks) field_text.push_back(CH_SPACE);
        foreach (lead[i]) field_text.push_back(lead[i]);
        repeat (zfill + zprec) field_text.push_back(CH_ZERO);
        foreach (digit_chars[i]) field_text.push_back(digit_chars[i]);
        if (r.left_justify) repeat (blanks) field_text.push_back(CH_SPACE);
      end

      // cut to the field cap; empty text gives one marker result
      total = (field_text.size() > MAX_FIELD_DEF) ? MAX_FIELD_DEF : field_text.size();
      if (total == 0) begin
        e.ch = 8'h00;
        e.valid = 1'b0;
        e.fin = 1'b1;
        e.len = 7'd0;
        expected_chars.push_back(e);
      end else begin
        for (int unsigned k = 0; k < total; k++) begin
          e.ch = field_text[k];
          e.valid = 1'b1;
          e.fin = (k + 1 == total);
          e.len = 7'(total);
          expected_chars.push_back(e);
        end
      end
    endfunction

    function void check_char(logic [7:0] ch, logic valid, logic fin, logic [6:0] len);
      char_res_t e;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character result: out_char %h char_valid %b last %b",
                 $time, ch, valid, fin);
        mismatches++;
        return;
      end
      e = expected_chars.pop_front();
      if (ch !== e.ch) begin
        $display("%0t: out_char expected %h actual %h", $time, e.ch, ch);
        mismatches++;
      end
      if (valid !== e.valid) begin
        $display("%0t: char_valid expected %b actual %b", $time, e.valid, valid);
        mismatches++;
      end
      if (fin !== e.fin) begin
        $display("%0t: last expected %b actual %b", $time, e.fin, fin);
        mismatches++;
      end
      if (len !== e.len) begin
        $display("%0t: total_length expected %0d actual %0d", $time, e.len, len);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  cmd = CMD_CHAR;
  logic [31:0] value = '0;
  logic [6:0]  field_width = '0;
  logic [5:0]  precision_digits = '0;
  logic        has_precision = 1'b0;
  logic        left_justify = 1'b0;
  logic        zero_pad = 1'b0;
  logic [1:0]  sign_mode = SIGN_NONE;
  logic        alt_prefix = 1'b0;
  logic        strobe;
  logic [7:0]  out_char;
  logic        char_valid;
  logic        last;
  logic [6:0]  total_length;

  text_scoreboard sb = new();
  int cycle_count = 0;

  integer_field_formatter DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .value(value),
    .field_width(field_width),
    .precision_digits(precision_digits),
    .has_precision(has_precision),
    .left_justify(left_justify),
    .zero_pad(zero_pad),
    .sign_mode(sign_mode),
    .alt_prefix(alt_prefix),
    .strobe(strobe),
    .out_char(out_char),
    .char_valid(char_valid),
    .last(last),
    .total_length(total_length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && strobe) sb.check_char(out_char, char_valid, last, total_length);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** integer_field_formatter: FAILED **");
      $finish;
    end
  end

  function automatic fmt_req_t make_req(logic [2:0] c, logic [31:0] v, logic [6:0] fw,
                                        logic [5:0] prec, logic hasp, logic lj,
                                        logic zp, logic [1:0] sm, logic alt);
    fmt_req_t r;
    r.cmd = c;
    r.value = v;
    r.field_width = fw;
    r.precision_digits = prec;
    r.has_precision = hasp;
    r.left_justify = lj;
    r.zero_pad = zp;
    r.sign_mode = sm;
    r.alt_prefix = alt;
    return r;
  endfunction

  // random request, weighted toward short fields
  function automatic fmt_req_t random_req();
    fmt_req_t r;
    int sel;
    r.cmd = ($urandom_range(99) < 90) ? 3'($urandom_range(CMD_CHAR, CMD_UHEX)) :
                                        3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    sel = $urandom_range(9);
    if (sel < 3) begin
      r.value = $urandom_range(20);
      if ($urandom_range(3) == 0) r.value = 32'd0 - r.value;
    end else if (sel == 3) begin
      case ($urandom_range(3))
        0: r.value = 32'h0000_0000;
        1: r.value = 32'h8000_0000;
        2: r.value = 32'h7FFF_FFFF;
        default: r.value = 32'hFFFF_FFFF;
      endcase
    end else if (sel < 6) begin
      r.value = $urandom >> $urandom_range(31);
    end else begin
      r.value = $urandom;
    end
    sel = $urandom_range(9);
    r.field_width = (sel < 6) ? 7'($urandom_range(16)) :
                    (sel < 9) ? 7'($urandom_range(64)) : 7'($urandom_range(127));
    sel = $urandom_range(9);
    r.precision_digits = (sel < 7) ? 6'($urandom_range(12)) : 6'($urandom_range(62));
    r.has_precision = 1'($urandom_range(1));
    r.left_justify = 1'($urandom_range(1));
    r.zero_pad = ($urandom_range(9) < 3);
    r.sign_mode = 2'($urandom_range(3));
    r.alt_prefix = 1'($urandom_range(1));
    return r;
  endfunction

  // present a request and hold it until taken; returns at the accepting edge
  task automatic send_request(input fmt_req_t r);
    start <= 1'b1;
    cmd <= r.cmd;
    value <= r.value;
    field_width <= r.field_width;
    precision_digits <= r.precision_digits;
    has_precision <= r.has_precision;
    left_justify <= r.left_justify;
    zero_pad <= r.zero_pad;
    sign_mode <= r.sign_mode;
    alt_prefix <= r.alt_prefix;
    do @(posedge clk); while (busy);
    sb.note_request(r);
  endtask

  task automatic pause_sender(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold off until every expected character has come out
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_phase(input int count, input int idle_pct);
    for (int i = 0; i < count; i++) begin
      send_request(random_req());
      if ($urandom_range(99) < idle_pct)
        pause_sender(($urandom_range(99) < 85) ? $urandom_range(1, 4) : $urandom_range(5, 90));
    end
  endtask

  initial begin
    fmt_req_t directed[$];

    // character conversion, including byte zero and padding both ways
    directed.push_back(make_req(CMD_CHAR, 32'h0000_0041, 7'd0, 6'd5, 1, 0, 1, SIGN_PLUS, 1));
    directed.push_back(make_req(CMD_CHAR, 32'hFFFF_FFFF, 7'd5, 6'd0, 0, 0, 0, SIGN_NONE, 0));
    directed.push_back(make_req(CMD_CHAR, 32'h1234_5600, 7'd4, 6'd0, 0, 1, 0, SIGN_NONE, 0));
    directed.push_back(make_req(CMD_CHAR, 32'h0000_007A, 7'd127, 6'd0, 0, 1, 0, SIGN_NONE, 0));
    // signed decimal extremes and sign modes
    directed.push_back(make_req(CMD_SDEC, 32'h8000_0000, 7'd0, 6'd0, 0, 0, 0, SIGN_NONE, 0));
    directed.push_back(make_req(CMD_SDEC, 32'h7FFF_FFFF, 7'd0, 6'd0, 0, 0, 0, SIGN_PLUS, 0));
    directed.push_back(make_req(CMD_SDEC, 32'h0000_0000, 7'd3, 6'd0, 0, 0, 0, SIGN_SPACE, 0));
    directed.push_back(make_req(CMD_SDEC, 32'h0000_0005, 7'd2, 6'd0, 0, 0, 0, SIGN_UNUSED, 1));
    directed.push_back(make_req(CMD_SDEC, 32'hFFFF_FFD6, 7'd10, 6'd0, 0, 1, 1, SIGN_NONE, 0));
    directed.push_back(make_req(CMD_SDEC, 32'h0000_0007, 7'd0, 6'd0, 0, 0, 1, SIGN_PLUS, 0));
    directed.push_back(make_req(CMD_SDEC, 32'h0000_0000, 7'd6, 6'd0, 1, 0, 0, SIGN_PLUS, 0));
    directed.push_back(make_req(CMD_SDEC, 32'hFFFF_FFFF, 7'd64, 6'd10, 1, 1, 0, SIGN_NONE, 0));
    directed.push_back(make_req(CMD_SDEC, 32'd12345, 7'd0, 6'd40, 0, 0, 0, SIGN_SPACE, 0));
    // unsigned decimal, precision cases
    directed.push_back(make_req(CMD_UDEC, 32'hFFFF_FFFF, 7'd0, 6'd0, 0, 0, 0, SIGN_PLUS, 1));
    directed.push_back(make_req(CMD_UDEC, 32'h0000_0000, 7'd0, 6'd0, 1, 0, 0, SIGN_NONE, 0));
    directed.push_back(make_req(CMD_UDEC, 32'd123, 7'd0, 6'd62, 1, 0, 0, SIGN_NONE, 0));
    directed.push_back(make_req(CMD_UDEC, 32'd99, 7'd64, 6'd0, 0, 0, 1, SIGN_NONE, 0));
    directed.push_back(make_req(CMD_UDEC, 32'd1, 7'd127, 6'd0, 0, 0, 0, SIGN_NONE, 0));
    // hex, prefix on zero and narrow widths
    directed.push_back(make_req(CMD_LHEX, 32'hDEAD_BEEF, 7'd0, 6'd0, 0, 0, 0, SIGN_NONE, 1));
    directed.push_back(make_req(CMD_UHEX, 32'hABCD_EF01, 7'd20, 6'd0, 0, 0, 1, SIGN_NONE, 1));
    directed.push_back(make_req(CMD_LHEX, 32'h0000_0000, 7'd0, 6'd0, 0, 0, 0, SIGN_NONE, 1));
    directed.push_back(make_req(CMD_UHEX, 32'h0000_0000, 7'd0, 6'd0, 1, 0, 0, SIGN_NONE, 1));
    directed.push_back(make_req(CMD_LHEX, 32'h0000_0001, 7'd1, 6'd0, 0, 0, 1, SIGN_NONE, 1));
    directed.push_back(make_req(CMD_LHEX, 32'h0000_0ABC, 7'd64, 6'd62, 1, 1, 0, SIGN_NONE, 1));
    // unused commands give the empty marker
    directed.push_back(make_req(CMD_UNUSED_LO, 32'hFFFF_FFFF, 7'd8, 6'd3, 1, 0, 0, SIGN_NONE, 0));
    directed.push_back(make_req(CMD_UNUSED_HI, 32'd42, 7'd0, 6'd0, 0, 0, 0, SIGN_NONE, 0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_request(directed[i]);
    drain();

    // random: sender idles at times, then more often, then never
    run_phase(78, 34);
    drain();
    run_phase(78, 47);
    drain();
    run_phase(79, 0);
    drain();

    // watch for stray results after the last one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** integer_field_formatter: PASSED **");
    end else begin
      $display("** integer_field_formatter: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
